// ===== rtl/address_blacklist_filter_hash_core_macros.svh =====
// assertion macros for the address blacklist filter core
// used by files that assert; expects aclk and aresetn in scope
`ifndef ADDRESS_BLACKLIST_FILTER_HASH_CORE_MACROS_SVH
`define ADDRESS_BLACKLIST_FILTER_HASH_CORE_MACROS_SVH

// same-cycle implication
`define ABFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABFH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/abfh_pkg.sv =====
// shared types, codes and the hash fold for the address blacklist filter
// no dependencies
package abfh_pkg;

    localparam int ADDR_W = 64;
    localparam int MAC_W  = 48;
    localparam int HASH_W = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_BAD   = 2'd3;

    localparam logic [1:0] KIND_V4  = 2'd0;
    localparam logic [1:0] KIND_V6  = 2'd1;
    localparam logic [1:0] KIND_MAC = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic REG_RATE_LIMIT = 1'b0;
    localparam logic REG_HASH_SIZE  = 1'b1;

    localparam logic [HASH_W-1:0] HASH_SIZE_RESET = 16'd1024;

    // probe word walking along the cell row
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] key_high;
        logic [ADDR_W-1:0] key_low;
        logic [MAC_W-1:0]  mac;
    } probe_t;

    // entry write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] key_high;
        logic [ADDR_W-1:0] key_low;
    } wr_t;

    typedef struct packed {
        logic              black;
        logic              bvalid;
        logic [HASH_W-1:0] bucket;
        logic [1:0]        status;
    } result_t;

    // xor of the little-endian 16-bit words of masked keys, mac and vlan
    function automatic logic [HASH_W-1:0] fold_hash(
        input logic [ADDR_W-1:0] key_high,
        input logic [ADDR_W-1:0] key_low,
        input logic [MAC_W-1:0]  mac,
        input logic [HASH_W-1:0] vlan
    );
        logic [HASH_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < ADDR_W / HASH_W; k++) begin
            acc = acc ^ key_high[k*HASH_W +: HASH_W] ^ key_low[k*HASH_W +: HASH_W];
        end
        for (int k = 0; k < MAC_W / HASH_W; k++) begin
            acc = acc ^ mac[k*HASH_W +: HASH_W];
        end
        return {acc[7:0], acc[15:8]} ^ vlan;
    endfunction

endpackage

// ===== rtl/abfh_cell.sv =====
// one table slot of the blacklist row: stored entry plus a probe stage
// depends on abfh_pkg
module abfh_cell import abfh_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] count,
    input  wr_t              wr,
    input  probe_t           probe_in,
    output probe_t           probe_out
);

    logic [1:0]        ent_kind_reg;
    logic [ADDR_W-1:0] ent_high_reg;
    logic [ADDR_W-1:0] ent_low_reg;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic              occupied;
    logic              ip_match;
    logic              mac_match;

    always_comb begin
        occupied  = count > CNT_W'(INDEX);
        ip_match  = (ent_kind_reg == probe_in.kind) && (ent_high_reg == probe_in.key_high)
                    && (ent_low_reg == probe_in.key_low);
        mac_match = (ent_kind_reg == KIND_MAC) && (ent_high_reg == '0)
                    && (ent_low_reg == {{(ADDR_W-MAC_W){1'b0}}, probe_in.mac});
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | (occupied & (ip_match | mac_match));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    // slot is written when it is the next free one
    always_ff @(posedge aclk) begin
        if (wr.en && count == CNT_W'(INDEX)) begin
            ent_kind_reg <= wr.kind;
            ent_high_reg <= wr.key_high;
            ent_low_reg  <= wr.key_low;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== rtl/abfh_mod.sv =====
// iterative 16-bit remainder unit, one restoring step per cycle
// depends on abfh_pkg; divisor zero acts as 65536
module abfh_mod import abfh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [HASH_W-1:0] divisor,
    output logic              done,
    output logic [HASH_W-1:0] rem
);

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [HASH_W-1:0] quo_reg,  quo_next;
    logic [HASH_W-1:0] rem_reg,  rem_next;
    logic [HASH_W:0]   div_reg,  div_next;
    logic              done_reg, done_next;
    logic [HASH_W:0]   trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[HASH_W-1]};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = CNT_W'(HASH_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = (divisor == '0) ? {1'b1, {HASH_W{1'b0}}} : {1'b0, divisor};
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - CNT_W'(1);
            quo_next  = {quo_reg[HASH_W-2:0], 1'b0};
            rem_next  = (trial >= div_reg) ? HASH_W'(trial - div_reg) : trial[HASH_W-1:0];
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/address_blacklist_filter_hash_core.sv =====
// Address blacklist filter with xor-fold bucket hash. One word in, one word
// out, handled one at a time. Add and clear words are answered from the result
// state after acceptance; a check word sends its probe down a row of TABLE_ENTRIES
// cells, one cell per cycle, while a 16-step remainder unit reduces the hash.
// A check ends once both the walk along the row and the remainder unit are
// done. The output register holds a finished result while the next word is taken.
// Table slots hold no reset value; only slots below the entry count can ever
// match. Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata:
// register 0 is rate_limit_on, register 1 is hash_size (0 means 65536).
// depends on abfh_pkg, abfh_cell, abfh_mod and the assertion macro header
`include "address_blacklist_filter_hash_core_macros.svh"

module address_blacklist_filter_hash_core import abfh_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // addr_high, addr_low, mac_addr, vlan_id
    input  logic [3:0]   s_tuser,   // operation, addr_kind
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // bucket
    output logic [3:0]   m_tuser    // blacklisted, bucket_valid, status
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_RESULT} state_t;

    state_t            state_reg,      state_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic              rate_on_reg,    rate_on_next;
    logic [HASH_W-1:0] hash_size_reg,  hash_size_next;
    logic              chain_done_reg, chain_done_next;
    logic              div_done_reg,   div_done_next;
    logic              hit_reg,        hit_next;
    result_t           res_reg,        res_next;
    result_t           out_reg,        out_next;
    logic              m_tvalid_reg,   m_tvalid_next;

    // unpacked input word
    logic [1:0]        in_op;
    logic [1:0]        in_kind;
    logic [ADDR_W-1:0] in_high;
    logic [ADDR_W-1:0] in_low;
    logic [MAC_W-1:0]  in_mac;
    logic [HASH_W-1:0] in_vlan;
    logic [ADDR_W-1:0] key_high;
    logic [ADDR_W-1:0] key_low;
    logic              s_accept;
    logic              kind_is_ip;

    probe_t            chain [0:TABLE_ENTRIES];
    wr_t               wr;
    logic              div_done;
    logic [HASH_W-1:0] div_rem;
    logic              walk_done;
    logic              mod_done;
    logic              hit_now;

    assign in_op    = s_tuser[1:0];
    assign in_kind  = s_tuser[3:2];
    assign in_high  = s_tdata[63:0];
    assign in_low   = s_tdata[127:64];
    assign in_mac   = s_tdata[175:128];
    assign in_vlan  = s_tdata[191:176];
    assign s_accept = s_tvalid && s_tready;
    assign kind_is_ip = (in_kind == KIND_V4) || (in_kind == KIND_V6);

    // keep only the address bits the kind uses
    always_comb begin
        key_high = (in_kind == KIND_V6) ? in_high : '0;
        if (in_kind == KIND_V4) begin
            key_low = {32'b0, in_low[31:0]};
        end else if (in_kind == KIND_MAC) begin
            key_low = {{(ADDR_W-MAC_W){1'b0}}, in_low[MAC_W-1:0]};
        end else begin
            key_low = in_low;
        end
    end

    // probe injection at the head of the row
    always_comb begin
        chain[0].valid    = s_accept && (in_op == OP_CHECK) && kind_is_ip;
        chain[0].hit      = 1'b0;
        chain[0].kind     = in_kind;
        chain[0].key_high = key_high;
        chain[0].key_low  = key_low;
        chain[0].mac      = in_mac;
    end

    // entry write into the next free slot
    always_comb begin
        wr.en       = s_accept && (in_op == OP_ADD) && (in_kind != KIND_BAD)
                      && (count_reg < CNT_W'(TABLE_ENTRIES));
        wr.kind     = in_kind;
        wr.key_high = key_high;
        wr.key_low  = key_low;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        abfh_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .count     (count_reg),
            .wr        (wr),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
    end

    // hash reduction runs alongside the walk
    abfh_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (chain[0].valid),
        .dividend (fold_hash(key_high, key_low, in_mac, in_vlan)),
        .divisor  (hash_size_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign walk_done = chain_done_reg || chain[TABLE_ENTRIES].valid;
    assign mod_done  = div_done_reg || div_done;
    assign hit_now   = chain[TABLE_ENTRIES].valid ? chain[TABLE_ENTRIES].hit : hit_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rate_on_next    = rate_on_reg;
        hash_size_next  = hash_size_reg;
        chain_done_next = chain_done_reg;
        div_done_next   = div_done_reg;
        hit_next        = hit_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RATE_LIMIT: rate_on_next   = cfg_wdata[0];
                REG_HASH_SIZE:  hash_size_next = cfg_wdata;
                default: ;
            endcase
        end

        // output word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_next   = '0;
                    state_next = ST_RESULT;
                    unique case (in_op)
                        OP_ADD: begin
                            if (in_kind == KIND_BAD) begin
                                res_next.status = STAT_INVALID;
                            end else if (count_reg >= CNT_W'(TABLE_ENTRIES)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CHECK: begin
                            if (kind_is_ip) begin
                                chain_done_next = 1'b0;
                                div_done_next   = 1'b0;
                                state_next      = ST_WALK;
                            end else begin
                                res_next.status = STAT_INVALID;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            res_next.status = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (chain[TABLE_ENTRIES].valid) begin
                    chain_done_next = 1'b1;
                    hit_next        = chain[TABLE_ENTRIES].hit;
                end
                if (div_done) begin
                    div_done_next = 1'b1;
                end
                if (walk_done && mod_done) begin
                    res_next.black = hit_now;
                    if (!hit_now && rate_on_reg) begin
                        res_next.bvalid = 1'b1;
                        res_next.bucket = div_rem;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rate_on_reg    <= 1'b0;
            hash_size_reg  <= HASH_SIZE_RESET;
            chain_done_reg <= 1'b0;
            div_done_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rate_on_reg    <= rate_on_next;
            hash_size_reg  <= hash_size_next;
            chain_done_reg <= chain_done_next;
            div_done_reg   <= div_done_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        hit_reg <= hit_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.bucket;
    assign m_tuser  = {out_reg.status, out_reg.bvalid, out_reg.black};

    // entry count never passes the table size
    `ABFH_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_ENTRIES), "entry count overflow")
    // a probe only leaves the row while a check is being walked
    `ABFH_ASSERT_IMP(a_probe_in_walk, chain[TABLE_ENTRIES].valid, state_reg == ST_WALK, "stray probe at row end")
    // the remainder unit finishes only during a check
    `ABFH_ASSERT_IMP(a_mod_in_walk, div_done, state_reg == ST_WALK, "stray remainder completion")
    // a stored add bumps the count by one
    `ABFH_ASSERT_NXT(a_add_count, wr.en, count_reg == $past(count_reg) + CNT_W'(1), "add did not advance count")
    // a bucket is never given for a blacklisted packet
    `ABFH_ASSERT_IMP(a_bucket_clean, m_tvalid_reg && out_reg.bvalid, !out_reg.black, "bucket with blacklisted")

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for address_blacklist_filter_hash_core: directed and
// random add, check and clear words against an in-line blocklist predictor
// depends on abfh_pkg and the core rtl
module tb_top;
    import abfh_pkg::*;

    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all

    // one input word, split into its fields
    typedef struct {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [47:0] mac;
        logic [15:0] vlan;
    } filter_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;   // addr_high, addr_low, mac_addr, vlan_id
    logic [3:0]   s_tuser = '0;   // operation, addr_kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;        // bucket
    logic [3:0]   m_tuser;        // blacklisted, bucket_valid, status

    address_blacklist_filter_hash_core #(.TABLE_ENTRIES(SLOTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor copy of the blocklist and of the two registers
    logic [63:0] blocked_hi   [SLOTS];
    logic [63:0] blocked_lo   [SLOTS];
    logic [1:0]  blocked_kind [SLOTS];
    int          blocked_count   = 0;
    logic        rate_limit_cfg  = 1'b0;
    logic [15:0] hash_size_cfg   = HASH_SIZE_RESET;

    result_t     pending_verdicts [$];   // one expected result per accepted word
    int          fail_count  = 0;
    bit          gaps_on     = 1'b1;     // random idling on both sides
    int          stall_left  = 0;
    int          quiet_cycles = 0;

    // ---------------------------------------------------------------- predictor

    // keep only the address bits that the kind uses
    function automatic logic [63:0] kind_mask(input logic [1:0] kind, input logic [63:0] v);
        if (kind == KIND_V4)
            return {32'd0, v[31:0]};
        if (kind == KIND_MAC)
            return {16'd0, v[47:0]};
        return v;
    endfunction

    function automatic bit on_blocklist(input logic [1:0] kind, input logic [63:0] hi,
                                        input logic [63:0] lo);
        for (int i = 0; i < blocked_count; i++) begin
            if (blocked_kind[i] == kind && blocked_hi[i] == hi && blocked_lo[i] == lo)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // xor of 16-bit words, each word taking its first byte (most significant
    // byte of the big-endian value) as its low half
    function automatic logic [15:0] fold_be(input logic [63:0] v, input int nbytes);
        logic [15:0] acc;
        acc = '0;
        for (int k = 0; k < nbytes; k += 2)
            acc ^= {v[8*(nbytes-2-k) +: 8], v[8*(nbytes-1-k) +: 8]};
        return acc;
    endfunction

    // works out the result of one accepted word and moves the blocklist along
    function automatic result_t filter_predict(input filter_word_t w);
        result_t     r;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [15:0] sum;
        r      = '0;
        key_hi = (w.kind == KIND_V6) ? w.hi : 64'd0;
        key_lo = kind_mask(w.kind, w.lo);
        case (w.op)
            OP_ADD: begin
                if (w.kind == KIND_BAD) begin
                    r.status = STAT_INVALID;
                end else if (blocked_count >= SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    blocked_hi[blocked_count]   = key_hi;
                    blocked_lo[blocked_count]   = key_lo;
                    blocked_kind[blocked_count] = w.kind;
                    blocked_count++;
                end
            end
            OP_CHECK: begin
                if (w.kind == KIND_MAC || w.kind == KIND_BAD) begin
                    r.status = STAT_INVALID;
                end else if (on_blocklist(w.kind, key_hi, key_lo) ||
                             on_blocklist(KIND_MAC, 64'd0, {16'd0, w.mac})) begin
                    r.black = 1'b1;
                end else if (rate_limit_cfg) begin
                    sum = fold_be({16'd0, w.mac}, 6) ^ w.vlan;
                    if (w.kind == KIND_V6)
                        sum ^= fold_be(w.hi, 8) ^ fold_be(w.lo, 8);
                    else
                        sum ^= fold_be(key_lo, 4);
                    // a zero size stands for 65536 buckets
                    r.bucket = (hash_size_cfg == 16'd0) ? sum : sum % hash_size_cfg;
                    r.bvalid = 1'b1;
                end
            end
            OP_CLEAR: blocked_count = 0;
            default:  r.status = STAT_INVALID;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic filter_word_t random_word();
        filter_word_t w;
        w.op   = 2'($urandom_range(0, 3));
        w.kind = 2'($urandom_range(0, 3));
        w.hi   = {$urandom, $urandom};
        w.lo   = {$urandom, $urandom};
        w.mac  = {16'($urandom), $urandom};
        w.vlan = 16'($urandom);
        return w;
    endfunction

    function automatic filter_word_t make_word(input logic [1:0] op, input logic [1:0] kind,
                                               input logic [63:0] hi, input logic [63:0] lo,
                                               input logic [47:0] mac, input logic [15:0] vlan);
        filter_word_t w;
        w.op   = op;
        w.kind = kind;
        w.hi   = hi;
        w.lo   = lo;
        w.mac  = mac;
        w.vlan = vlan;
        return w;
    endfunction

    // offers one word and returns in the time step of its acceptance, tvalid
    // still high: the caller either offers the next word or drops tvalid
    task automatic send_word(input filter_word_t w);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.vlan, w.mac, w.lo, w.hi};
        s_tuser  <= {w.kind, w.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(filter_predict(w));
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called once the core is idle
    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_RATE_LIMIT)
            rate_limit_cfg = val[0];
        else
            hash_size_cfg = val;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_verdict();
        result_t want;
        if (pending_verdicts.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
        end else begin
            want = pending_verdicts.pop_front();
            if (m_tuser[0] !== want.black) begin
                $error("blacklisted: expected %0d, got %0d", want.black, m_tuser[0]);
                fail_count++;
            end
            if (m_tuser[1] !== want.bvalid) begin
                $error("bucket_valid: expected %0d, got %0d", want.bvalid, m_tuser[1]);
                fail_count++;
            end
            if (m_tdata !== want.bucket) begin
                $error("bucket: expected %0d, got %0d", want.bucket, m_tdata);
                fail_count++;
            end
            if (m_tuser[3:2] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_tuser[3:2]);
                fail_count++;
            end
        end
    endtask

    // take results, with random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_verdict();
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // watchdog: too long without any handshake means the core has hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // reset state: empty list, rate limiting off, so checks give nothing
    task automatic test_empty_table();
        send_word(make_word(OP_CHECK, KIND_V4, '0, '0, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V6, '1, '1, '1, '1));
        send_word(make_word(OP_CLEAR, KIND_V4, '1, '1, '1, '1));
        send_word(make_word(OP_CHECK, KIND_V4, '1, '1, '1, '1));
    endtask

    // matching per kind, masking of unused bits, invalid codes, duplicates
    task automatic test_match_rules();
        settle();
        write_reg(REG_RATE_LIMIT, 16'h0001);
        // ipv4 entry from a word with garbage above bit 31
        send_word(make_word(OP_ADD, KIND_V4, '1, '1, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V4, 64'h0123_4567_89ab_cdef,
                            64'h1234_5678_ffff_ffff, 48'h1, 16'h1));
        send_word(make_word(OP_CHECK, KIND_V4, '0, 64'h0000_0000_ffff_fffe, '0, '1));
        // ipv6 entry and a near miss in the last bit
        send_word(make_word(OP_ADD, KIND_V6, '1, '1, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V6, '1, '1, 48'h2, 16'h0));
        send_word(make_word(OP_CHECK, KIND_V6, '1, 64'hffff_ffff_ffff_fffe, '0, '0));
        // mac entry, garbage above bit 47, hit through the packet mac
        send_word(make_word(OP_ADD, KIND_MAC, '1, 64'hdead_ffff_ffff_ffff, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V4, '0, 64'h0a00_0001, '1, 16'h55aa));
        send_word(make_word(OP_CHECK, KIND_V6, 64'h2001_0db8_0000_0000, 64'h1, '0, 16'h8000));
        // invalid kinds and operation
        send_word(make_word(OP_ADD, KIND_BAD, '0, 64'h1, '0, '0));
        send_word(make_word(OP_CHECK, KIND_MAC, '0, '1, '0, '0));
        send_word(make_word(OP_CHECK, KIND_BAD, '0, '1, '0, '0));
        send_word(make_word(OP_BAD, KIND_V4, '0, '0, '0, '0));
        // duplicate entry still matches
        send_word(make_word(OP_ADD, KIND_V4, '0, 64'hffff_ffff, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V4, '0, 64'hffff_ffff, '0, '0));
        // all-zero and all-one packets that miss
        send_word(make_word(OP_CHECK, KIND_V4, '0, '0, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V4, '1, 64'hffff_fff0, 48'hffff_ffff_fffe, '1));
        // clear empties the list
        send_word(make_word(OP_CLEAR, KIND_BAD, '0, '0, '0, '0));
        send_word(make_word(OP_CHECK, KIND_V4, '0, 64'hffff_ffff, '1, '0));
    endtask

    // fill every slot, then one add too many
    task automatic test_table_full();
        logic [1:0] kind;
        send_word(make_word(OP_CLEAR, KIND_V4, '0, '0, '0, '0));
        for (int i = 0; i <= SLOTS; i++) begin
            kind = 2'(i % 3);
            send_word(make_word(OP_ADD, kind, 64'(i + 1), 64'(i + 100), '0, '0));
        end
        send_word(make_word(OP_CHECK, KIND_V4, '0, 64'(SLOTS - 1 + 100), '0, '0));
        send_word(make_word(OP_CHECK, KIND_MAC == 2'(SLOTS % 3) ? KIND_V4 : 2'(SLOTS % 3),
                            64'(SLOTS + 1), 64'(SLOTS + 100), '0, '0));
        send_word(make_word(OP_CHECK, KIND_V6, 64'(SLOTS + 1), 64'(SLOTS + 100),
                            48'(SLOTS + 100), '0));
    endtask

    // bucket reduction at the extreme sizes, zero standing for 65536
    task automatic test_hash_sizes();
        logic [15:0] sizes [3];
        sizes = '{16'd0, 16'd1, 16'hffff};
        foreach (sizes[i]) begin
            settle();
            write_reg(REG_HASH_SIZE, sizes[i]);
            send_word(make_word(OP_CHECK, KIND_V6, {$urandom, $urandom}, {$urandom, $urandom},
                                {16'($urandom), $urandom}, '1));
            send_word(make_word(OP_CHECK, KIND_V4, '0, {32'd0, $urandom}, '0, 16'($urandom)));
        end
    endtask

    // one setting of the registers, then well-formed runs of clear, adds and
    // checks with random content, mixed with noise words
    task automatic run_traffic_phase(input logic rate_on, input logic [15:0] size,
                                     input int words);
        filter_word_t w;
        filter_word_t e;
        filter_word_t pool [$];
        int           sent;
        int           pick;
        settle();
        write_reg(REG_RATE_LIMIT, {15'($urandom), rate_on});
        write_reg(REG_HASH_SIZE, size);
        sent = 0;
        while (sent < words) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) == 0)
                settle();
            if ($urandom_range(0, 2) != 0) begin
                w    = random_word();
                w.op = OP_CLEAR;
                send_word(w);
                pool.delete();
                sent++;
            end
            // up to a couple past the slot count, so that full is seen
            repeat ($urandom_range(0, SLOTS + 2)) begin
                w      = random_word();
                w.op   = OP_ADD;
                w.kind = 2'($urandom_range(0, 2));
                send_word(w);
                pool.push_back(w);
                sent++;
            end
            repeat ($urandom_range(4, 20)) begin
                w      = random_word();
                w.op   = OP_CHECK;
                w.kind = 2'($urandom_range(0, 1));
                pick   = $urandom_range(0, 99);
                if (pick < 40 && pool.size() != 0) begin
                    e = pool[$urandom_range(0, pool.size() - 1)];
                    if (e.kind == KIND_MAC) begin
                        w.mac = e.lo[47:0];
                    end else begin
                        w.kind = e.kind;
                        w.lo   = (e.kind == KIND_V4) ? {w.lo[63:32], e.lo[31:0]} : e.lo;
                        if (e.kind == KIND_V6)
                            w.hi = e.hi;
                    end
                end else if (pick < 52) begin
                    w = random_word();
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(1'b0, HASH_SIZE_RESET, 150);
        run_traffic_phase(1'b1, HASH_SIZE_RESET, 200);
        run_traffic_phase(1'b1, 16'd1, 150);
        run_traffic_phase(1'b1, 16'hffff, 150);
        run_traffic_phase(1'b1, 16'd0, 200);
        run_traffic_phase(1'b1, 16'($urandom_range(2, 65534)), 200);
        run_traffic_phase(1'b1, 16'($urandom_range(2, 40)), 150);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_match_rules();
        test_table_full();
        test_hash_sizes();
        test_random_traffic();
        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
